[hdl/zspf_pkg.sv]
// ---------------------------------------------------------------------------
// zspf_pkg: shared types and constants
// Sizes, controller states and the command/status bundles that join the
// zero-sum pair finder controller to its datapath.
// ---------------------------------------------------------------------------
package zspf_pkg;

    localparam int MAX_ITEMS  = 64;
    localparam int VALUE_BITS = 16;
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W      = IDX_W + 1;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_INS,
        S_CHK,
        S_TOP,
        S_CMP,
        S_SKL_TOP,
        S_SKL,
        S_SKR_TOP,
        S_SKR,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_VALUE
    } wr_sel_t;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    addr_ins;
        wr_sel_t wr_sel;
        logic    pos_dec;
        logic    cnt_inc;
        logic    scan_init;
        logic    l_inc;
        logic    r_dec;
        logic    match;
        logic    finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic pos_zero;
        logic last;
        logic cnt_ge2;
        logic gt;
        logic l_lt_r;
        logic sum_zero;
        logic sum_pos;
        logic eq_lo;
        logic eq_hi;
        logic out_free;
        logic pend_valid;
    } status_t;

endpackage

[hdl/zspf_in_if.sv]
// ---------------------------------------------------------------------------
// zspf_in_if: input channel
// Valid/ready channel carrying one set element per item.
// ---------------------------------------------------------------------------
interface zspf_in_if
    import zspf_pkg::*;
    ;
    logic   valid;
    logic   ready;
    value_t value;
    logic   last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

[hdl/zspf_out_if.sv]
// ---------------------------------------------------------------------------
// zspf_out_if: result channel
// Valid/ready channel carrying one zero-sum pair (or empty answer) per item.
// ---------------------------------------------------------------------------
interface zspf_out_if
    import zspf_pkg::*;
    ;
    logic   valid;
    logic   ready;
    logic   found;
    value_t low_member;
    value_t high_member;
    logic   last_result;
    logic   overflow;

    modport source (output valid, output found, output low_member, output high_member,
                    output last_result, output overflow, input ready);
    modport sink   (input valid, input found, input low_member, input high_member,
                    input last_result, input overflow, output ready);
endinterface

[hdl/zspf_ram.sv]
// ---------------------------------------------------------------------------
// zspf_ram: generic RAM
// One write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module zspf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

[hdl/zspf_datapath.sv]
// ---------------------------------------------------------------------------
// zspf_datapath: store, pointers and result register
// Keeps the sorted store, insertion and scan pointers, the pending pair and
// the output register; acts on controller commands.
// ---------------------------------------------------------------------------
module zspf_datapath
    import zspf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    output status_t status,
    zspf_in_if.sink    in_ch,
    zspf_out_if.source out_ch
);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [IDX_W-1:0] left_reg, left_next;
    logic [IDX_W-1:0] right_reg, right_next;
    logic             dropped_reg, dropped_next;
    logic             last_reg, last_next;
    value_t           v_reg, v_next;
    logic             pend_valid_reg, pend_valid_next;
    value_t           pend_lo_reg, pend_lo_next;
    value_t           pend_hi_reg, pend_hi_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_found_reg, out_found_next;
    value_t           out_lo_reg, out_lo_next;
    value_t           out_hi_reg, out_hi_next;
    logic             out_last_reg, out_last_next;
    logic             out_ovf_reg, out_ovf_next;

    logic             wr_en;
    value_t           wr_data;
    logic [IDX_W-1:0] rd_addr_a;
    value_t           rd_a, rd_b;
    logic [VALUE_BITS:0] sum;
    logic             push;
    logic             out_free;

    // store
    assign wr_en     = (cmd.wr_sel != WR_NONE);
    assign wr_data   = (cmd.wr_sel == WR_SHIFT) ? rd_a : v_reg;
    assign rd_addr_a = cmd.addr_ins ? (pos_reg - 1'b1) : left_reg;

    zspf_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (pos_reg),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_a),
        .rd_addr_b (right_reg),
        .rd_data_b (rd_b)
    );

    // status
    assign sum      = {rd_a[VALUE_BITS-1], rd_a} + {rd_b[VALUE_BITS-1], rd_b};
    assign out_free = !out_valid_reg || out_ch.ready;
    assign push     = (cmd.match && pend_valid_reg) || cmd.finish;

    always_comb
    begin
        status.full       = (count_reg == CNT_W'(MAX_ITEMS));
        status.pos_zero   = (pos_reg == '0);
        status.last       = last_reg;
        status.cnt_ge2    = (count_reg >= CNT_W'(2));
        status.gt         = (rd_a > v_reg);
        status.l_lt_r     = (left_reg < right_reg);
        status.sum_zero   = (sum == '0);
        status.sum_pos    = !sum[VALUE_BITS] && (sum != '0);
        status.eq_lo      = (rd_a == pend_lo_reg);
        status.eq_hi      = (rd_b == pend_hi_reg);
        status.out_free   = out_free;
        status.pend_valid = pend_valid_reg;
    end

    assign in_ch.ready = cmd.load;

    // next values
    always_comb
    begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        dropped_next    = dropped_reg;
        last_next       = last_reg;
        v_next          = v_reg;
        pend_valid_next = pend_valid_reg;
        pend_lo_next    = pend_lo_reg;
        pend_hi_next    = pend_hi_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_found_next  = out_found_reg;
        out_lo_next     = out_lo_reg;
        out_hi_next     = out_hi_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;

        if (cmd.load && in_ch.valid)
        begin
            v_next    = in_ch.value;
            last_next = in_ch.last_item;
            pos_next  = count_reg[IDX_W-1:0];
            if (status.full)
            begin
                dropped_next = 1'b1;
            end
        end
        if (cmd.pos_dec)
        begin
            pos_next = pos_reg - 1'b1;
        end
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.scan_init)
        begin
            left_next  = '0;
            right_next = IDX_W'(count_reg - 1'b1);
        end
        if (cmd.l_inc)
        begin
            left_next = left_reg + 1'b1;
        end
        if (cmd.r_dec)
        begin
            right_next = right_reg - 1'b1;
        end

        // result register: earlier pair leaves, last pair or empty at finish
        if (push)
        begin
            out_valid_next = 1'b1;
            out_found_next = pend_valid_reg;
            out_lo_next    = pend_valid_reg ? pend_lo_reg : '0;
            out_hi_next    = pend_valid_reg ? pend_hi_reg : '0;
            out_last_next  = cmd.finish;
            out_ovf_next   = dropped_reg;
        end
        if (cmd.match)
        begin
            pend_valid_next = 1'b1;
            pend_lo_next    = rd_a;
            pend_hi_next    = rd_b;
        end
        if (cmd.finish)
        begin
            pend_valid_next = 1'b0;
            count_next      = '0;
            dropped_next    = 1'b0;
            left_next       = '0;
            right_next      = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            dropped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            left_reg       <= left_next;
            right_reg      <= right_next;
            dropped_reg    <= dropped_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        last_reg      <= last_next;
        v_reg         <= v_next;
        pend_lo_reg   <= pend_lo_next;
        pend_hi_reg   <= pend_hi_next;
        out_found_reg <= out_found_next;
        out_lo_reg    <= out_lo_next;
        out_hi_reg    <= out_hi_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.found       = out_found_reg;
    assign out_ch.low_member  = out_lo_reg;
    assign out_ch.high_member = out_hi_reg;
    assign out_ch.last_result = out_last_reg;
    assign out_ch.overflow    = out_ovf_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> out_free)
        else $error("result pushed into a full output register");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (count_reg == '0) && !dropped_reg && !pend_valid_reg)
        else $error("set state not cleared after answer");

endmodule

[hdl/zspf_ctrl.sv]
// ---------------------------------------------------------------------------
// zspf_ctrl: controller
// Sequences insertion into the sorted store, the two-pointer scan with
// duplicate skipping, and the answer hand-off.
// ---------------------------------------------------------------------------
module zspf_ctrl
    import zspf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    input  logic    in_valid,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.wr_sel = WR_NONE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = 1'b1;
                if (in_valid)
                begin
                    state_next = status.full ? S_CHK : S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.addr_ins = 1'b1;
                if (status.pos_zero)
                begin
                    cmd.wr_sel  = WR_VALUE;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_CHK;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_INS:
            begin
                cmd.addr_ins = 1'b1;
                if (status.gt)
                begin
                    cmd.wr_sel  = WR_SHIFT;
                    cmd.pos_dec = 1'b1;
                    state_next  = S_LOAD;
                end
                else
                begin
                    cmd.wr_sel  = WR_VALUE;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_CHK;
                end
            end
            S_CHK:
            begin
                if (!status.last)
                begin
                    state_next = S_IDLE;
                end
                else if (status.cnt_ge2)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_TOP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_TOP:
            begin
                state_next = status.l_lt_r ? S_CMP : S_FIN;
            end
            S_CMP:
            begin
                if (status.sum_zero)
                begin
                    if (!status.pend_valid || status.out_free)
                    begin
                        cmd.match  = 1'b1;
                        state_next = S_SKL_TOP;
                    end
                end
                else if (status.sum_pos)
                begin
                    cmd.r_dec  = 1'b1;
                    state_next = S_TOP;
                end
                else
                begin
                    cmd.l_inc  = 1'b1;
                    state_next = S_TOP;
                end
            end
            S_SKL_TOP:
            begin
                state_next = status.l_lt_r ? S_SKL : S_SKR_TOP;
            end
            S_SKL:
            begin
                if (status.eq_lo)
                begin
                    cmd.l_inc  = 1'b1;
                    state_next = S_SKL_TOP;
                end
                else
                begin
                    state_next = S_SKR_TOP;
                end
            end
            S_SKR_TOP:
            begin
                state_next = status.l_lt_r ? S_SKR : S_TOP;
            end
            S_SKR:
            begin
                if (status.eq_hi)
                begin
                    cmd.r_dec  = 1'b1;
                    state_next = S_SKR_TOP;
                end
                else
                begin
                    state_next = S_TOP;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // checks
    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> $past(status.l_lt_r))
        else $error("compare with crossed pointers");

    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == S_IDLE))
        else $error("answer finished but controller not idle");

    a_ins_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS) |-> !$past(status.pos_zero))
        else $error("insertion read below store start");

endmodule

[hdl/zero_sum_pair_finder_unit.sv]
// Insertion: an element is accepted in S_IDLE; for each entry it shifts past, S_LOAD reads it
// and S_INS moves it up one place; then the element is written and S_CHK runs (dropped: S_CHK only).
// Input: ready only in S_IDLE, so no new element is taken before the last one is through the shift loop.
// Scan: after the closing element, each pointer step passes S_TOP then S_CMP; each result waits on ready.
// Reset: rst_n async active low empties the set and result register; store left as is.
// ---------------------------------------------------------------------------
// zero_sum_pair_finder_unit: top level
// Sorts a set of signed values and reports every distinct zero-sum pair.
// ---------------------------------------------------------------------------
module zero_sum_pair_finder_unit
    import zspf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    zspf_in_if.sink    in_ch,
    zspf_out_if.source out_ch
);

    cmd_t    cmd;
    status_t status;

    zspf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .in_valid (in_ch.valid),
        .cmd      (cmd)
    );

    zspf_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .status (status),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

[tb/sv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench: zero_sum_pair_finder_unit verification
// Feeds sets of signed values over the input channel, predicts every
// zero-sum pair with a sorted-store model and checks each result item.
// ---------------------------------------------------------------------------
module testbench;
    import zspf_pkg::*;

    typedef struct packed {
        value_t value;
        logic   last_item;
    } elem_t;

    typedef struct packed {
        logic   found;
        value_t low_member;
        value_t high_member;
        logic   last_result;
        logic   overflow;
    } pair_t;

    logic clk;
    logic rst_n;

    zspf_in_if  in_ch ();
    zspf_out_if out_ch ();

    zero_sum_pair_finder_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    elem_t  elem_q[$];
    pair_t  pair_q[$];
    int     err_cnt;
    bit     stim_done;
    bit     calm;

    // predictor state
    value_t sorted_set[MAX_ITEMS];
    int     set_cnt;
    bit     set_dropped;

    // insert one element, and on the closing one compute all pairs
    task automatic predict_pairs(input elem_t e);
        int     pos;
        int     li;
        int     ri;
        int     n;
        value_t lo;
        value_t hi;
        int     s;
        pair_t  p;
        begin
            n = 0;
            if (set_cnt < MAX_ITEMS)
            begin
                pos = set_cnt;
                while (pos > 0 && sorted_set[pos-1] > e.value)
                begin
                    sorted_set[pos] = sorted_set[pos-1];
                    pos--;
                end
                sorted_set[pos] = e.value;
                set_cnt++;
            end
            else
                set_dropped = 1'b1;
            if (e.last_item)
            begin
                if (set_cnt >= 2)
                begin
                    li = 0;
                    ri = set_cnt - 1;
                    while (li < ri)
                    begin
                        lo = sorted_set[li];
                        hi = sorted_set[ri];
                        s  = int'(lo) + int'(hi);
                        if (s == 0)
                        begin
                            p = '{1'b1, lo, hi, 1'b0, set_dropped};
                            pair_q.insert(pair_q.size(), p);
                            n++;
                            while (li < ri && sorted_set[li] == lo) li++;
                            while (ri > li && sorted_set[ri] == hi) ri--;
                        end
                        else if (s > 0)
                            ri--;
                        else
                            li++;
                    end
                end
                if (n == 0)
                begin
                    p = '{1'b0, '0, '0, 1'b1, set_dropped};
                    pair_q.insert(pair_q.size(), p);
                end
                else
                    pair_q[pair_q.size()-1].last_result = 1'b1;
                set_cnt     = 0;
                set_dropped = 1'b0;
            end
        end
    endtask

    // queue a set of n elements; mode picks the value shape
    task automatic queue_set(input int n, input int mode);
        elem_t e;
        value_t pool[$];
        int k;
        begin
            for (k = 0; k < n; k++)
            begin
                case (mode)
                    0: e.value = value_t'($urandom);
                    1: e.value = value_t'($urandom_range(0, 8)) - 16'sd4;
                    default:
                    begin
                        if (pool.size() > 0 && $urandom_range(0, 1))
                            e.value = -pool[$urandom_range(0, pool.size()-1)];
                        else
                            e.value = value_t'($urandom_range(0, 400)) - 16'sd200;
                        pool.insert(pool.size(), e.value);
                    end
                endcase
                e.last_item = (k == n - 1);
                elem_q.insert(elem_q.size(), e);
            end
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // input driver
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid     <= 1'b0;
            in_ch.value     <= '0;
            in_ch.last_item <= 1'b0;
            in_gap          <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid)
                predict_pairs('{in_ch.value, in_ch.last_item});
            if (in_gap > 0)
            begin
                in_gap      <= in_gap - 1;
                in_ch.valid <= 1'b0;
            end
            else if (elem_q.size() > 0)
            begin
                {in_ch.value, in_ch.last_item} <= elem_q.pop_front();
                in_ch.valid <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    in_gap <= $urandom_range(1, 17);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result monitor and ready stalls
    int out_gap;
    pair_t got;
    pair_t want;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_gap      <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.found, out_ch.low_member, out_ch.high_member,
                        out_ch.last_result, out_ch.overflow};
                if (pair_q.size() == 0)
                begin
                    $error("unexpected result item");
                    err_cnt++;
                end
                else
                begin
                    want = pair_q.pop_front();
                    if (got.found !== want.found)
                    begin
                        $error("found exp %0d got %0d", want.found, got.found);
                        err_cnt++;
                    end
                    if (got.low_member !== want.low_member)
                    begin
                        $error("low_member exp %0d got %0d", want.low_member,
                               got.low_member);
                        err_cnt++;
                    end
                    if (got.high_member !== want.high_member)
                    begin
                        $error("high_member exp %0d got %0d", want.high_member,
                               got.high_member);
                        err_cnt++;
                    end
                    if (got.last_result !== want.last_result)
                    begin
                        $error("last_result exp %0d got %0d", want.last_result,
                               got.last_result);
                        err_cnt++;
                    end
                    if (got.overflow !== want.overflow)
                    begin
                        $error("overflow exp %0d got %0d", want.overflow, got.overflow);
                        err_cnt++;
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap      <= out_gap - 1;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_gap      <= $urandom_range(1, 17) - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // stimulus and end of run
    initial
    begin
        int    total;
        int    n;
        int    mode;
        err_cnt     = 0;
        calm        = 1'b0;
        set_cnt     = 0;
        set_dropped = 1'b0;
        rst_n       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n = 1'b1;

        // directed: extremes, empty-ish sets, zero pair, duplicates
        elem_q.insert(elem_q.size(), '{16'sh7fff, 1'b1});
        elem_q.insert(elem_q.size(), '{-16'sd32768, 1'b0});
        elem_q.insert(elem_q.size(), '{16'sh7fff, 1'b1});
        elem_q.insert(elem_q.size(), '{16'sd0, 1'b0});
        elem_q.insert(elem_q.size(), '{16'sd0, 1'b1});
        elem_q.insert(elem_q.size(), '{16'sd0, 1'b1});
        elem_q.insert(elem_q.size(), '{16'sd3, 1'b0});
        elem_q.insert(elem_q.size(), '{-16'sd3, 1'b0});
        elem_q.insert(elem_q.size(), '{16'sd3, 1'b0});
        elem_q.insert(elem_q.size(), '{-16'sd3, 1'b0});
        elem_q.insert(elem_q.size(), '{-16'sd32767, 1'b0});
        elem_q.insert(elem_q.size(), '{16'sd32767, 1'b0});
        elem_q.insert(elem_q.size(), '{16'sd5, 1'b1});
        elem_q.insert(elem_q.size(), '{-16'sd1, 1'b0});
        elem_q.insert(elem_q.size(), '{16'sd2, 1'b1});
        // full store: 70 items, closing item dropped
        queue_set(70, 2);

        total = elem_q.size();
        while (total < 500)
        begin
            case ($urandom_range(0, 9))
                0:       begin n = 1; mode = 0; end
                1:       begin n = 66; mode = 1; end
                2, 3:    begin n = $urandom_range(2, 12); mode = 0; end
                4, 5:    begin n = $urandom_range(2, 10); mode = 1; end
                default: begin n = $urandom_range(2, 14); mode = 2; end
            endcase
            queue_set(n, mode);
            total += n;
        end

        // no idling over the last stretch of the run
        wait (elem_q.size() < 100);
        calm = 1'b1;

        wait (elem_q.size() == 0 && !in_ch.valid);
        wait (pair_q.size() == 0);
        repeat (300) @(posedge clk);
        if (err_cnt == 0)
            $display("PASS zero_sum_pair_finder_unit");
        else
            $display("FAIL zero_sum_pair_finder_unit");
        $finish;
    end

    // timeout
    initial
    begin
        #30000000;
        $display("FAIL zero_sum_pair_finder_unit");
        $finish;
    end
endmodule
